// ===== rtl/wsc_pkg.sv =====
// Package for the wavetable sound channel: request and result structs,
// operation codes, configuration register indexes and fixed constants.
// No dependencies.
`timescale 1ns / 1ps

package wsc_pkg;

    localparam int LEVEL_BITS  = 8;
    localparam int FREQ_BITS   = 11;
    localparam int LENGTH_BITS = 8;
    localparam int WAVE_BITS   = 128;
    localparam int CFG_IDX_W   = 3;

    localparam logic [LEVEL_BITS-1:0] MID_LEVEL = 8'h80;

    typedef enum logic [1:0] {
        OP_BASE_TICK   = 2'd0,
        OP_LENGTH_TICK = 2'd1,
        OP_TRIGGER     = 2'd2,
        OP_LOAD_LENGTH = 2'd3
    } op_t;

    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQUENCY_CODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_CODE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_ENABLE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_LOW       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_HIGH      = 3'd5;

    typedef struct packed {
        op_t                    operation;
        logic [LENGTH_BITS-1:0] length_load;
    } in_item_t;

    typedef struct packed {
        logic [LEVEL_BITS-1:0]  dac_value;
        logic                   sample_strobe;
        logic                   key_on;
        logic [LENGTH_BITS-1:0] length_now;
    } out_item_t;

    typedef struct packed {
        logic                 channel_enable;
        logic [FREQ_BITS-1:0] frequency_code;
        logic [1:0]           volume_code;
        logic                 length_enable;
    } ctrl_t;

endpackage

// ===== rtl/wsc_sample_shaper.sv =====
// Sample shaper: selects one table entry from the packed wave registers
// and scales it by the volume code into an 8-bit level. Uses wsc_pkg.
`timescale 1ns / 1ps

module wsc_sample_shaper #(
    parameter int TABLE_DEPTH = 32,
    parameter int SAMPLE_BITS = 4,
    parameter int IDX_W       = $clog2(TABLE_DEPTH)
) (
    input  logic [wsc_pkg::WAVE_BITS-1:0]  wave_bits,
    input  logic [IDX_W-1:0]               entry_index,
    input  logic [1:0]                     volume_code,
    output logic [wsc_pkg::LEVEL_BITS-1:0] level
);
    import wsc_pkg::*;

    localparam int TABLE_BITS = TABLE_DEPTH * SAMPLE_BITS;
    localparam int SHIFT_UP   = LEVEL_BITS - SAMPLE_BITS;

    logic [TABLE_BITS-1:0]  table_vec;
    logic [SAMPLE_BITS-1:0] entry;
    logic [LEVEL_BITS-1:0]  entry_ext;
    logic [LEVEL_BITS-1:0]  entry_down;

    for (genvar i = 0; i < TABLE_BITS; i++) begin : g_bits
        if (i < WAVE_BITS) begin : g_reg
            assign table_vec[i] = wave_bits[i];
        end else begin : g_zero
            assign table_vec[i] = 1'b0;
        end
    end

    always_comb begin
        entry      = table_vec[int'(entry_index) * SAMPLE_BITS +: SAMPLE_BITS];
        entry_ext  = LEVEL_BITS'(entry);
        entry_down = entry_ext >> (volume_code - 2'd1);
        if (volume_code == 2'd0) begin
            level = '0;
        end else begin
            level = LEVEL_BITS'(entry_down << SHIFT_UP);
        end
    end

endmodule

// ===== rtl/wsc_channel_state.sv =====
// Channel state: divider, table index, output buffer, DAC hold, trigger,
// key-on and length counter, updated once per request. Uses wsc_pkg and
// wsc_sample_shaper.
`timescale 1ns / 1ps

module wsc_channel_state #(
    parameter int TABLE_DEPTH = 32,
    parameter int SAMPLE_BITS = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  wsc_pkg::in_item_t             item,
    input  wsc_pkg::ctrl_t                ctrl,
    input  logic [wsc_pkg::WAVE_BITS-1:0] wave_bits,
    output wsc_pkg::out_item_t            result
);
    import wsc_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(TABLE_DEPTH - 1);

    logic [IDX_W-1:0]       index_reg, index_next, index_eff;
    logic [FREQ_BITS-1:0]   divider_reg, divider_next;
    logic [LEVEL_BITS-1:0]  buffer_reg, buffer_next;
    logic [LEVEL_BITS-1:0]  dac_reg, dac_next;
    logic                   pending_reg, pending_next;
    logic                   playing_reg, playing_next;
    logic [LENGTH_BITS-1:0] length_reg, length_next;
    logic [LEVEL_BITS-1:0]  level;
    logic                   step;
    logic                   silent;

    wsc_sample_shaper #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .SAMPLE_BITS(SAMPLE_BITS),
        .IDX_W      (IDX_W)
    ) u_shaper (
        .wave_bits  (wave_bits),
        .entry_index(index_eff),
        .volume_code(ctrl.volume_code),
        .level      (level)
    );

    always_comb begin
        step      = (item.operation == OP_BASE_TICK) && (divider_reg == '0);
        silent    = !ctrl.channel_enable || (ctrl.length_enable && length_reg == '0);
        index_eff = pending_reg ? '0 : index_reg;

        index_next   = index_reg;
        divider_next = divider_reg;
        buffer_next  = buffer_reg;
        dac_next     = dac_reg;
        pending_next = pending_reg;
        playing_next = playing_reg;
        length_next  = length_reg;

        case (item.operation)
            OP_BASE_TICK: begin
                if (step) begin
                    divider_next = ~ctrl.frequency_code;
                    dac_next     = buffer_reg;
                    if (silent) begin
                        buffer_next  = MID_LEVEL;
                        playing_next = 1'b0;
                    end else begin
                        if (pending_reg) begin
                            pending_next = 1'b0;
                            playing_next = 1'b1;
                        end
                        buffer_next = level;
                        index_next  = (index_eff == LAST_INDEX) ? '0 : index_eff + 1'b1;
                    end
                end else begin
                    divider_next = divider_reg - 1'b1;
                end
            end
            OP_LENGTH_TICK: begin
                if (ctrl.length_enable && length_reg != '0) begin
                    length_next = length_reg + 1'b1;
                end
            end
            OP_TRIGGER: begin
                pending_next = 1'b1;
            end
            OP_LOAD_LENGTH: begin
                length_next = item.length_load;
            end
            default: begin
                pending_next = pending_reg;
            end
        endcase

        result.dac_value     = dac_next;
        result.sample_strobe = step;
        result.key_on        = playing_next;
        result.length_now    = length_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            index_reg   <= '0;
            divider_reg <= '0;
            buffer_reg  <= MID_LEVEL;
            dac_reg     <= MID_LEVEL;
            pending_reg <= 1'b0;
            playing_reg <= 1'b0;
            length_reg  <= '0;
        end else if (advance) begin
            index_reg   <= index_next;
            divider_reg <= divider_next;
            buffer_reg  <= buffer_next;
            dac_reg     <= dac_next;
            pending_reg <= pending_next;
            playing_reg <= playing_next;
            length_reg  <= length_next;
        end
    end

    a_reload: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && advance && step |=> divider_reg == ~$past(ctrl.frequency_code))
        else $error("divider not reloaded after sample step");

    a_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && advance && step && silent
        |=> buffer_reg == MID_LEVEL && !playing_reg && $stable(index_reg))
        else $error("silent step did not park the channel");

    a_dac: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && advance && step |=> dac_reg == $past(buffer_reg))
        else $error("DAC did not take the buffered value");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && !advance |=> $stable(divider_reg) && $stable(length_reg)
                                && $stable(index_reg))
        else $error("state moved without a request");

endmodule

// ===== rtl/wavetable_sound_channel.sv =====
// Top level of the wavetable sound channel: configuration registers,
// request register, result register and handshakes.
// Uses wsc_pkg and wsc_channel_state.
//
// Usage:
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the six registers: channel
//   enable, frequency code, volume code, length enable and the two 64-bit
//   wave words. cfg_ready is always high; indexes past the list are dropped.
//   s_valid/s_ready/s_data carry one request: base tick, length tick,
//   trigger or length load. Each request yields exactly one result on
//   m_valid/m_ready/m_data: DAC level, sample strobe, key-on, length.
//   Each request passes from the request register to the result register,
//   which drives m_valid; one request is taken every cycle while results are
//   taken, bounded by the single-pass channel state update between the two.
//   When the receiver stalls, the result register holds and the request
//   register fills, then s_ready drops; nothing is lost.
//   Synchronous active-low reset empties both registers, clears the
//   configuration to zero and parks the channel at mid-level 0x80 with
//   the divider at zero, so the first base tick steps at once.
`timescale 1ns / 1ps

module wavetable_sound_channel #(
    parameter int TABLE_DEPTH = 32,
    parameter int SAMPLE_BITS = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [wsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  wsc_pkg::in_item_t             s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output wsc_pkg::out_item_t            m_data
);
    import wsc_pkg::*;

    ctrl_t                ctrl_reg;
    logic [63:0]          wave_low_reg;
    logic [63:0]          wave_high_reg;
    logic                 in_valid_reg;
    in_item_t             in_data_reg;
    logic                 m_valid_reg;
    out_item_t            m_data_reg;
    out_item_t            result;
    logic                 advance;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg      <= '0;
            wave_low_reg  <= '0;
            wave_high_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_CHANNEL_ENABLE: ctrl_reg.channel_enable <= cfg_data[0];
                CFG_FREQUENCY_CODE: ctrl_reg.frequency_code <= cfg_data[FREQ_BITS-1:0];
                CFG_VOLUME_CODE:    ctrl_reg.volume_code    <= cfg_data[1:0];
                CFG_LENGTH_ENABLE:  ctrl_reg.length_enable  <= cfg_data[0];
                CFG_WAVE_LOW:       wave_low_reg            <= cfg_data;
                CFG_WAVE_HIGH:      wave_high_reg           <= cfg_data;
                default:            ctrl_reg                <= ctrl_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            m_data_reg <= result;
        end
    end

    wsc_channel_state #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_state (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .item     (in_data_reg),
        .ctrl     (ctrl_reg),
        .wave_bits({wave_high_reg, wave_low_reg}),
        .result   (result)
    );

endmodule

// ===== tb/tb_wavetable_sound_channel.sv =====
// Testbench for wavetable_sound_channel: directed and random requests with
// random sender gaps and receiver stalls, checked against a behavioral model.
// Depends on wsc_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb_wavetable_sound_channel;
    import wsc_pkg::*;

    localparam int TABLE_DEPTH = 32;
    localparam int SAMPLE_BITS = 4;
    localparam int RAND_PHASES = 12;
    localparam int PHASE_ITEMS = 118;
    localparam int LONG_HOLD   = 100;
    localparam int HOLD_AFTER  = 400;
    localparam int STUCK_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;
    localparam int TAIL_CYCLES = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    class channel_scoreboard;
        logic                   chan_on;
        logic [FREQ_BITS-1:0]   freq;
        logic [1:0]             vol;
        logic                   len_on;
        logic [WAVE_BITS-1:0]   wave;

        logic [4:0]             idx;
        logic [FREQ_BITS-1:0]   divider;
        logic [LEVEL_BITS-1:0]  next_level;
        logic [LEVEL_BITS-1:0]  dac_level;
        logic                   trig_pending;
        logic                   playing;
        logic [LENGTH_BITS-1:0] len_cnt;

        out_item_t   channel_outputs_q[$];
        int unsigned errors;
        int unsigned results_checked;

        function new();
            chan_on         = 1'b0;
            freq            = '0;
            vol             = '0;
            len_on          = 1'b0;
            wave            = '0;
            idx             = '0;
            divider         = '0;
            next_level      = MID_LEVEL;
            dac_level       = MID_LEVEL;
            trig_pending    = 1'b0;
            playing         = 1'b0;
            len_cnt         = '0;
            errors          = 0;
            results_checked = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] index, logic [63:0] value);
            case (index)
                CFG_CHANNEL_ENABLE: chan_on = value[0];
                CFG_FREQUENCY_CODE: freq = value[FREQ_BITS-1:0];
                CFG_VOLUME_CODE:    vol = value[1:0];
                CFG_LENGTH_ENABLE:  len_on = value[0];
                CFG_WAVE_LOW:       wave[63:0] = value;
                CFG_WAVE_HIGH:      wave[127:64] = value;
                default: ;
            endcase
        endfunction

        function void play_sample_step();
            logic [SAMPLE_BITS-1:0] sample;
            logic [SAMPLE_BITS-1:0] shifted;
            logic [LEVEL_BITS-1:0]  widened;
            dac_level = next_level;
            if (!chan_on || (len_on && len_cnt == '0)) begin
                next_level = MID_LEVEL;
                playing    = 1'b0;
                return;
            end
            if (trig_pending) begin
                idx          = '0;
                trig_pending = 1'b0;
                playing      = 1'b1;
            end
            if (vol == 2'd0) begin
                next_level = '0;
            end else begin
                sample     = wave[idx * SAMPLE_BITS +: SAMPLE_BITS];
                shifted    = sample >> (vol - 2'd1);
                widened    = LEVEL_BITS'(shifted);
                next_level = widened << (LEVEL_BITS - SAMPLE_BITS);
            end
            idx = idx + 5'd1;
        endfunction

        function void note_request(in_item_t req);
            out_item_t res;
            logic      strobe;
            strobe = 1'b0;
            case (req.operation)
                OP_BASE_TICK: begin
                    if (divider == '0) begin
                        play_sample_step();
                        strobe  = 1'b1;
                        divider = 11'd2047 - freq;
                    end else begin
                        divider = divider - 11'd1;
                    end
                end
                OP_LENGTH_TICK: begin
                    if (len_on && len_cnt != '0)
                        len_cnt = len_cnt + 8'd1;
                end
                OP_TRIGGER: trig_pending = 1'b1;
                OP_LOAD_LENGTH: len_cnt = req.length_load;
                default: ;
            endcase
            res.dac_value     = dac_level;
            res.sample_strobe = strobe;
            res.key_on        = playing;
            res.length_now    = len_cnt;
            channel_outputs_q.push_back(res);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            results_checked++;
            if (channel_outputs_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result %0d with no request pending: dac=%02h strobe=%0b key=%0b len=%0d",
                             $time, results_checked, got.dac_value, got.sample_strobe,
                             got.key_on, got.length_now);
                return;
            end
            want = channel_outputs_q.pop_front();
            if (got.dac_value !== want.dac_value || got.sample_strobe !== want.sample_strobe ||
                got.key_on !== want.key_on || got.length_now !== want.length_now) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result %0d mismatch (expected/actual): dac %02h/%02h strobe %0b/%0b key %0b/%0b len %0d/%0d",
                             $time, results_checked, want.dac_value, got.dac_value,
                             want.sample_strobe, got.sample_strobe, want.key_on, got.key_on,
                             want.length_now, got.length_now);
            end
        endfunction

        function int pending();
            return channel_outputs_q.size();
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [63:0]           cfg_data  = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;

    channel_scoreboard sb = new();
    int unsigned       stuck_cycles = 0;
    int                burst_left   = 0;

    wavetable_sound_channel #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_request(s_data);
            if (m_valid && m_ready)
                sb.check_result(m_data);
            if (cfg_valid && cfg_ready)
                sb.set_register(cfg_index, cfg_data);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
                if (stuck_cycles >= STUCK_LIMIT) begin
                    $display("FAILURE");
                    $finish;
                end
            end
        end
    end

    initial begin : result_sink
        logic [15:0] pattern;
        int unsigned left;
        bit          held;
        pattern = '1;
        left    = 0;
        held    = 1'b0;
        forever begin
            @(posedge aclk);
            // hold off once while the sender keeps offering
            if (!held && sb.results_checked >= HOLD_AFTER) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            if (left == 0) begin
                pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom | $urandom);
                left    = $urandom_range(16, 64);
            end
            m_ready <= pattern[0];
            pattern = {pattern[0], pattern[15:1]};
            left--;
        end
    end

    task automatic write_register(input logic [CFG_IDX_W-1:0] index, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic apply_settings(input logic en, input logic [FREQ_BITS-1:0] freq,
                                  input logic [1:0] vol, input logic len,
                                  input logic [63:0] lo, input logic [63:0] hi);
        write_register(CFG_CHANNEL_ENABLE, 64'(en));
        write_register(CFG_FREQUENCY_CODE, 64'(freq));
        write_register(CFG_VOLUME_CODE, 64'(vol));
        write_register(CFG_LENGTH_ENABLE, 64'(len));
        write_register(CFG_WAVE_LOW, lo);
        write_register(CFG_WAVE_HIGH, hi);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_request(input op_t op, input logic [LENGTH_BITS-1:0] load);
        in_item_t req;
        req.operation   = op;
        req.length_load = load;
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 32);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    function automatic logic [LENGTH_BITS-1:0] random_load();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return 8'($urandom_range(1, 4));
            3:       return 8'($urandom_range(248, 255));
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [63:0] random_wave();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic random_settings(input int phase);
        logic                 en;
        logic                 len;
        logic [1:0]           vol;
        logic [FREQ_BITS-1:0] freq;
        logic [63:0]          lo;
        logic [63:0]          hi;
        en   = ($urandom_range(0, 4) != 0);
        len  = 1'($urandom_range(0, 1));
        vol  = 2'($urandom_range(0, 3));
        freq = ($urandom_range(0, 2) == 0) ? 11'd2047 : 11'($urandom_range(1984, 2047));
        lo   = random_wave();
        hi   = random_wave();
        if (phase == 0) begin
            en   = 1'b1;
            freq = 11'd2047;
            vol  = 2'd3;
            len  = 1'b1;
            lo   = '1;
            hi   = '1;
        end
        // slowest rate last so the divider does not starve later phases
        if (phase == RAND_PHASES - 1)
            freq = '0;
        apply_settings(en, freq, vol, len, lo, hi);
    endtask

    task automatic random_traffic(input int count);
        int sent;
        int pick;
        int run;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                wait_drained();
            end else if (pick < 50) begin
                if ($urandom_range(0, 3) == 0) begin
                    send_request(OP_TRIGGER, random_load());
                    sent++;
                end
                run = $urandom_range(1, 16);
                repeat (run) begin
                    send_request(OP_BASE_TICK, random_load());
                    sent++;
                end
            end else if (pick < 70) begin
                send_request(OP_LOAD_LENGTH, 8'($urandom_range(246, 255)));
                sent++;
                run = $urandom_range(1, 12);
                repeat (run) begin
                    send_request(($urandom_range(0, 2) == 0) ? OP_BASE_TICK : OP_LENGTH_TICK,
                                 random_load());
                    sent++;
                end
            end else if (pick < 85) begin
                send_request(OP_TRIGGER, random_load());
                sent++;
                run = $urandom_range(1, 8);
                repeat (run) begin
                    send_request(OP_BASE_TICK, random_load());
                    sent++;
                end
            end else begin
                run = $urandom_range(1, 6);
                repeat (run) begin
                    send_request(op_t'($urandom_range(0, 3)), random_load());
                    sent++;
                end
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: trigger while off, length ops with length disabled
        send_request(OP_TRIGGER, 8'h00);
        send_request(OP_LENGTH_TICK, 8'hFF);
        send_request(OP_LOAD_LENGTH, 8'hFF);
        send_request(OP_LENGTH_TICK, 8'h00);
        send_request(OP_LOAD_LENGTH, 8'h00);
        wait_drained();

        // first base tick steps at once; length stop and 255 wrap
        write_register(CFG_SPARE_A, '1);
        write_register(CFG_SPARE_B, '1);
        apply_settings(1'b1, 11'd2047, 2'd1, 1'b1,
                       64'hFEDC_BA98_7654_3210, 64'h0123_4567_89AB_CDEF);
        send_request(OP_BASE_TICK, 8'h00);
        send_request(OP_LOAD_LENGTH, 8'd254);
        send_request(OP_BASE_TICK, 8'h55);
        send_request(OP_BASE_TICK, 8'hAA);
        send_request(OP_BASE_TICK, 8'h00);
        send_request(OP_LENGTH_TICK, 8'h00);
        send_request(OP_LENGTH_TICK, 8'h00);
        send_request(OP_BASE_TICK, 8'h00);
        send_request(OP_LENGTH_TICK, 8'h00);
        send_request(OP_TRIGGER, 8'h00);
        send_request(OP_BASE_TICK, 8'h00);
        wait_drained();

        // frequency change lands at next reload; quarter volume
        apply_settings(1'b1, 11'd2046, 2'd3, 1'b0, '0, '1);
        repeat (5) send_request(OP_BASE_TICK, 8'h00);
        wait_drained();

        // mute
        apply_settings(1'b1, 11'd2047, 2'd0, 1'b0, '1, '1);
        repeat (3) send_request(OP_BASE_TICK, 8'h00);
        wait_drained();

        for (int p = 0; p < RAND_PHASES; p++) begin
            random_settings(p);
            random_traffic(PHASE_ITEMS);
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/wsc_pkg.sv
rtl/wsc_sample_shaper.sv
rtl/wsc_channel_state.sv
rtl/wavetable_sound_channel.sv
tb/tb_wavetable_sound_channel.sv
